FILE: sv/res_pkg.sv
// ----------------------------------------------------------------------------
// res_pkg: shared types and constants of the readiness event set
// Slot field layout and mode codes used across the block.
// ----------------------------------------------------------------------------
package res_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam int MAX_BATCH_DEF = 64;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_MODIFY = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_LEVEL  = 3'd3,
    MODE_NOTIFY = 3'd4,
    MODE_CLOSE  = 3'd5,
    MODE_COLLECT = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [3:0] BIT_ERR = 4'd4;
  localparam logic [3:0] BIT_HUP = 4'd8;

  // per-slot record held in the slot memory
  typedef struct packed {
    logic [3:0]  interest;
    logic        edge_md;
    logic        one_shot;
    logic [63:0] user_word;
    logic [3:0]  level;
    logic [3:0]  last_seen;
    logic [3:0]  pending;
    logic [3:0]  reported;
    logic        disarmed;
    logic        closed;
  } slot_rec_t;

  function automatic logic [3:0] cur_ready(slot_rec_t r);
    return r.level & (r.interest | BIT_ERR | BIT_HUP);
  endfunction
endpackage

FILE: sv/res_if.sv
// ----------------------------------------------------------------------------
// res_if: valid/ready channels of the readiness event set
// Command channel and result channel.
// ----------------------------------------------------------------------------
interface res_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [5:0]  slot;
  logic [3:0]  interest;
  logic        edge_triggered;
  logic        one_shot;
  logic [63:0] user_data;
  logic [3:0]  ready_bits;
  logic [6:0]  max_events;
  modport source (output valid, mode, slot, interest, edge_triggered, one_shot,
                  user_data, ready_bits, max_events, input ready);
  modport sink (input valid, mode, slot, interest, edge_triggered, one_shot,
                user_data, ready_bits, max_events, output ready);
endinterface

interface res_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        event_valid;
  logic [3:0]  event_bits;
  logic [63:0] event_data;
  logic [5:0]  event_slot;
  logic        last_result;
  modport source (output valid, status, event_valid, event_bits, event_data,
                  event_slot, last_result, input ready);
  modport sink (input valid, status, event_valid, event_bits, event_data,
                event_slot, last_result, output ready);
endinterface

FILE: sv/readiness_event_set.sv
// ----------------------------------------------------------------------------
// readiness_event_set: watched-slot table with edge/level event collection
// Slot records live in one memory; a sequencer walks it for collect.
// ----------------------------------------------------------------------------
// channel | dir | content
// cmd     | in  | mode, slot, interest, flags, user word, bits, batch size
// evt     | out | status, event flag, bits, user word, slot, last flag
//
// Control items pass through accept, memory read, then update and result. A
// collect makes one poll pass and one report pass over the slot memory,
// each entry read and then written back where needed through its single
// read/write port; the report pass ends early once the batch is full.
// Each result waits in the output register while the sequencer holds.
// After reset the valid and target-level stores read as zero through
// flip-flop valid bits.
module readiness_event_set #(
  parameter int ENTRIES = res_pkg::ENTRIES_DEF,
  parameter int MAX_BATCH = res_pkg::MAX_BATCH_DEF
) (
  input logic clk,
  input logic rst,
  res_cmd_if.sink cmd,
  res_evt_if.source evt
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_UPD = 7'b0000100,
    S_PRD = 7'b0001000, S_PWR = 7'b0010000, S_RRD = 7'b0100000,
    S_RWR = 7'b1000000
  } state_t;

  state_t state;
  res_pkg::slot_rec_t mem [ENTRIES];
  res_pkg::slot_rec_t rd;
  logic [ENTRIES-1:0] ev;     // entry valid
  logic [ENTRIES-1:0] lv;     // record written at least once (level known)
  logic [AW-1:0] addr;
  logic [CW-1:0] idx;
  logic [6:0] lim, cnt;
  logic [CW-1:0] tot, tot_nx;  // entries left with events after the poll pass
  logic we;
  res_pkg::slot_rec_t wd;

  // held command
  logic [2:0] mode;
  logic [3:0] interest, rbits;
  logic et, os;
  logic [63:0] ud;
  logic inr;

  logic ovalid;
  logic [1:0] ostat;
  logic oev, olast;
  logic [3:0] obits;
  logic [63:0] odata;
  logic [5:0] oslot;

  assign cmd.ready = (state == S_IDLE);
  assign evt.valid = ovalid;
  assign evt.status = ostat;
  assign evt.event_valid = oev;
  assign evt.event_bits = obits;
  assign evt.event_data = odata;
  assign evt.event_slot = oslot;
  assign evt.last_result = olast;

  logic ent_v, lvl_k;
  res_pkg::slot_rec_t r;
  assign ent_v = ev[addr];
  assign lvl_k = lv[addr];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd <= mem[addr];
  end

  // record as read, with an unwritten level seen as zero
  always_comb begin
    r = rd;
    if (!lvl_k) r.level = 4'd0;
  end

  logic [3:0] cur, ls, rep;
  always_comb begin
    we = 1'b0;
    wd = r;
    cur = res_pkg::cur_ready(r);
    ls = r.last_seen & ~r.pending;
    rep = r.reported;
    unique case (state)
      S_UPD: begin
        unique case (mode)
          res_pkg::MODE_ADD, res_pkg::MODE_MODIFY: begin
            wd.interest = interest; wd.edge_md = et; wd.one_shot = os;
            wd.user_word = ud; wd.disarmed = 1'b0; wd.last_seen = 4'd0;
            wd.pending = r.level & (interest | res_pkg::BIT_ERR | res_pkg::BIT_HUP);
            wd.reported = wd.pending;
            if (mode == res_pkg::MODE_ADD) wd.closed = 1'b0;
            we = inr && ((mode == res_pkg::MODE_ADD) ? !(ent_v && !r.closed) : ent_v);
          end
          res_pkg::MODE_LEVEL: begin
            wd.level = rbits; we = inr;
          end
          res_pkg::MODE_NOTIFY: begin
            wd.pending = r.pending | rbits; we = inr && ent_v && !r.closed;
          end
          res_pkg::MODE_CLOSE: begin
            wd.closed = 1'b1; wd.pending = r.pending | res_pkg::BIT_HUP;
            we = inr && ent_v;
          end
          default: ;
        endcase
        // write once, on the cycle the result is loaded
        if (ovalid && !evt.ready) we = 1'b0;
      end
      S_PWR: begin
        if (ent_v) begin
          if (r.closed) begin
            wd.reported = res_pkg::BIT_HUP; we = 1'b1;
          end else if (!r.disarmed) begin
            we = 1'b1;
            if (r.edge_md) begin
              wd.pending = 4'd0; wd.last_seen = cur;
              wd.reported = rep | (cur & ~ls);
            end else begin
              wd.reported = cur;
            end
          end
        end
      end
      S_RWR: begin
        if (ent_v && r.reported != 4'd0 && !ovalid) begin
          we = 1'b1; wd.reported = 4'd0;
          if (r.one_shot) wd.disarmed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign tot_nx = tot + CW'(ent_v && wd.reported != 4'd0);

  logic [6:0] mx_sat;
  assign mx_sat = (cmd.max_events > 7'(MAX_BATCH)) ? 7'(MAX_BATCH) : cmd.max_events;
  logic end_scan;
  assign end_scan = (idx == CW'(ENTRIES - 1));

  // a new result enters the output register
  logic ld;
  always_comb begin
    ld = 1'b0;
    if (state == S_UPD) ld = !ovalid || evt.ready;
    if (state == S_RWR)
      ld = (!ovalid && ent_v && r.reported != 4'd0) ||
           ((!ovalid || evt.ready) && !(ent_v && r.reported != 4'd0) &&
            end_scan && cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ovalid <= 1'b0; ev <= '0; lv <= '0;
    end else begin
      ovalid <= ld || (ovalid && !evt.ready);
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          mode <= cmd.mode; interest <= cmd.interest;
          et <= cmd.edge_triggered; os <= cmd.one_shot; ud <= cmd.user_data;
          rbits <= cmd.ready_bits; lim <= mx_sat; cnt <= '0; tot <= '0;
          inr <= (32'(cmd.slot) < ENTRIES);
          addr <= (32'(cmd.slot) < ENTRIES && cmd.mode != res_pkg::MODE_COLLECT) ?
                  AW'(cmd.slot) : '0;
          idx <= '0;
          if (cmd.mode == res_pkg::MODE_COLLECT && cmd.max_events != 7'd0) begin
            state <= S_PRD;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_UPD;
        S_UPD: if (!ovalid || evt.ready) begin
          ostat <= (mode == res_pkg::MODE_ADD) ?
                     (!inr ? res_pkg::ST_NOT_FOUND :
                      (ent_v && !r.closed) ? res_pkg::ST_PRESENT : res_pkg::ST_OK) :
                   ((mode == res_pkg::MODE_MODIFY || mode == res_pkg::MODE_DELETE) &&
                    !(inr && ent_v)) ? res_pkg::ST_NOT_FOUND : res_pkg::ST_OK;
          if (we && mode == res_pkg::MODE_ADD) ev[addr] <= 1'b1;
          if (we && mode == res_pkg::MODE_ADD) lv[addr] <= 1'b1;
          if (we && mode == res_pkg::MODE_LEVEL) lv[addr] <= 1'b1;
          if (mode == res_pkg::MODE_DELETE && inr) ev[addr] <= 1'b0;
          oev <= 1'b0; obits <= '0; odata <= '0; oslot <= '0; olast <= 1'b1;
          state <= S_IDLE;
        end
        S_PRD: state <= S_PWR;
        S_PWR: begin
          tot <= tot_nx;
          if (end_scan) begin
            // cap the batch at the number of entries that will report
            lim <= (32'(tot_nx) < 32'(lim)) ? 7'(tot_nx) : lim;
            addr <= '0; idx <= '0; state <= S_RRD;
          end else begin
            addr <= addr + 1'b1; idx <= idx + 1'b1; state <= S_PRD;
          end
        end
        S_RRD: state <= S_RWR;
        S_RWR: if (!ovalid || evt.ready) begin
          if (ent_v && r.reported != 4'd0 && !ovalid) begin
            ostat <= res_pkg::ST_OK; oev <= 1'b1; obits <= r.reported;
            odata <= r.user_word; oslot <= 6'(addr);
            olast <= end_scan || (cnt + 1'b1 == lim);
            cnt <= cnt + 1'b1;
            if (end_scan || cnt + 1'b1 == lim) state <= S_IDLE;
            else begin
              addr <= addr + 1'b1; idx <= idx + 1'b1; state <= S_RRD;
            end
          end else if (!(ent_v && r.reported != 4'd0)) begin
            if (end_scan) begin
              // nothing more: close with an empty result if none was sent
              if (cnt == '0) begin
                ostat <= res_pkg::ST_OK; oev <= 1'b0; obits <= '0; odata <= '0;
                oslot <= '0; olast <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              addr <= addr + 1'b1; idx <= idx + 1'b1; state <= S_RRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/res_checker.sv
// ----------------------------------------------------------------------------
// res_checker: port-level checks of the readiness event set
// Watches the handshakes on the top level and is bound to it.
// ----------------------------------------------------------------------------
module res_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic evt_valid,
  input logic evt_ready,
  input logic evt_event_valid,
  input logic [3:0] evt_event_bits,
  input logic [1:0] evt_status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready straight after a transfer");
  a_bits: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_event_valid |-> evt_event_bits != 4'd0 && evt_status == 2'd0)
    else $error("event with no bits");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_event_valid |-> evt_event_bits == 4'd0)
    else $error("empty result carries bits");
endmodule

bind readiness_event_set res_checker u_res_checker (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .evt_valid(evt.valid), .evt_ready(evt.ready),
  .evt_event_valid(evt.event_valid), .evt_event_bits(evt.event_bits),
  .evt_status(evt.status)
);

FILE: tb/readiness_event_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// readiness_event_set_tb: self-checking bench of the readiness event set
// Drives slot commands and collects from a queue, predicts every result
// with a local table model and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module readiness_event_set_tb;

  typedef struct {
    res_pkg::mode_t mode;
    logic [5:0]  slot;
    logic [3:0]  interest;
    logic        edge_triggered;
    logic        one_shot;
    logic [63:0] user_data;
    logic [3:0]  ready_bits;
    logic [6:0]  max_events;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic        event_valid;
    logic [3:0]  event_bits;
    logic [63:0] event_data;
    logic [5:0]  event_slot;
    logic        last_result;
  } evt_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  res_cmd_if cmd ();
  res_evt_if evt ();

  readiness_event_set uut (.clk(clk), .rst(rst), .cmd(cmd), .evt(evt));

  always #1 clk = ~clk;

  // predictor state
  logic        tv_valid [64];
  logic [3:0]  tv_interest [64];
  logic        tv_edge [64];
  logic        tv_oneshot [64];
  logic [63:0] tv_word [64];
  logic [3:0]  tv_level [64];
  logic [3:0]  tv_seen [64];
  logic [3:0]  tv_pending [64];
  logic [3:0]  tv_reported [64];
  logic        tv_disarmed [64];
  logic        tv_closed [64];

  cmd_item_t   pending_cmds [$];
  evt_item_t   expected_evts [$];
  int          errors = 0;
  bit          stim_done = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  int          hold_off = 0;

  function automatic logic [3:0] ready_now(int s);
    return tv_level[s] & (tv_interest[s] | res_pkg::BIT_ERR | res_pkg::BIT_HUP);
  endfunction

  function automatic void arm_slot(cmd_item_t c);
    int s;
    s = c.slot;
    tv_interest[s] = c.interest;
    tv_edge[s] = c.edge_triggered;
    tv_oneshot[s] = c.one_shot;
    tv_word[s] = c.user_data;
    tv_disarmed[s] = 1'b0;
    tv_seen[s] = 4'd0;
    tv_pending[s] = ready_now(s);
    tv_reported[s] = ready_now(s);
  endfunction

  function automatic void push_result(logic [1:0] st, logic v, logic [3:0] b,
                                      logic [63:0] d, logic [5:0] s, logic l);
    evt_item_t e;
    e.status = st; e.event_valid = v; e.event_bits = b;
    e.event_data = d; e.event_slot = s; e.last_result = l;
    expected_evts.push_back(e);
  endfunction

  function automatic void predict_collect(int mx);
    int lim, n;
    logic [3:0] cur, chg;
    if (mx == 0) begin
      push_result(res_pkg::ST_OK, 1'b0, 4'd0, 64'd0, 6'd0, 1'b1);
      return;
    end
    lim = mx > 64 ? 64 : mx;
    for (int s = 0; s < 64; s++) begin
      if (!tv_valid[s]) continue;
      if (tv_closed[s]) begin
        tv_reported[s] = res_pkg::BIT_HUP;
        continue;
      end
      if (tv_disarmed[s]) continue;
      cur = ready_now(s);
      if (tv_edge[s]) begin
        chg = tv_pending[s];
        tv_pending[s] = 4'd0;
        tv_seen[s] = tv_seen[s] & ~chg;
        tv_reported[s] = tv_reported[s] | (cur & ~tv_seen[s]);
        tv_seen[s] = cur;
      end else begin
        tv_reported[s] = cur;
      end
    end
    n = 0;
    for (int s = 0; s < 64 && n < lim; s++) begin
      if (!tv_valid[s] || tv_reported[s] == 4'd0) continue;
      push_result(res_pkg::ST_OK, 1'b1, tv_reported[s], tv_word[s], s[5:0], 1'b0);
      n++;
      if (tv_oneshot[s]) tv_disarmed[s] = 1'b1;
      tv_reported[s] = 4'd0;
    end
    if (n == 0) push_result(res_pkg::ST_OK, 1'b0, 4'd0, 64'd0, 6'd0, 1'b1);
    else expected_evts[$].last_result = 1'b1;
  endfunction

  function automatic void predict_item(cmd_item_t c);
    int s;
    logic [1:0] st;
    s = c.slot;
    st = res_pkg::ST_OK;
    case (c.mode)
      res_pkg::MODE_ADD: begin
        if (tv_valid[s] && tv_closed[s]) tv_valid[s] = 1'b0;
        if (tv_valid[s]) st = res_pkg::ST_PRESENT;
        else begin
          tv_valid[s] = 1'b1;
          tv_closed[s] = 1'b0;
          arm_slot(c);
        end
      end
      res_pkg::MODE_MODIFY: begin
        if (!tv_valid[s]) st = res_pkg::ST_NOT_FOUND;
        else arm_slot(c);
      end
      res_pkg::MODE_DELETE: begin
        if (!tv_valid[s]) st = res_pkg::ST_NOT_FOUND;
        else tv_valid[s] = 1'b0;
      end
      res_pkg::MODE_LEVEL: tv_level[s] = c.ready_bits;
      res_pkg::MODE_NOTIFY:
        if (tv_valid[s] && !tv_closed[s]) tv_pending[s] = tv_pending[s] | c.ready_bits;
      res_pkg::MODE_CLOSE:
        if (tv_valid[s]) begin
          tv_closed[s] = 1'b1;
          tv_pending[s] = tv_pending[s] | res_pkg::BIT_HUP;
        end
      res_pkg::MODE_COLLECT: begin
        predict_collect(int'(c.max_events));
        return;
      end
      default: ;
    endcase
    push_result(st, 1'b0, 4'd0, 64'd0, 6'd0, 1'b1);
  endfunction

  function automatic cmd_item_t make_cmd(res_pkg::mode_t m, int s, int ev, int bits,
                                         int mx);
    cmd_item_t c;
    c.mode = m;
    c.slot = s[5:0];
    c.interest = ev[3:0];
    c.edge_triggered = 1'($urandom_range(0, 1));
    c.one_shot = $urandom_range(0, 3) == 0;
    c.user_data = {$urandom, $urandom};
    c.ready_bits = bits[3:0];
    c.max_events = mx[6:0];
    return c;
  endfunction

  // most random traffic stays on a few slots so that slots live long enough
  function automatic cmd_item_t random_cmd();
    int s, r, mx;
    res_pkg::mode_t m;
    s = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    r = $urandom_range(0, 99);
    if (r < 18) m = res_pkg::MODE_ADD;
    else if (r < 26) m = res_pkg::MODE_MODIFY;
    else if (r < 32) m = res_pkg::MODE_DELETE;
    else if (r < 52) m = res_pkg::MODE_LEVEL;
    else if (r < 68) m = res_pkg::MODE_NOTIFY;
    else if (r < 73) m = res_pkg::MODE_CLOSE;
    else if (r < 97) m = res_pkg::MODE_COLLECT;
    else m = res_pkg::MODE_NONE;
    r = $urandom_range(0, 9);
    mx = (r == 0) ? $urandom_range(0, 127) : (r < 3 ? 0 : $urandom_range(1, 6));
    return make_cmd(m, s, $urandom_range(0, 15), $urandom_range(0, 15), mx);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.mode <= res_pkg::MODE_NONE;
      cmd.slot <= '0;
      cmd.interest <= '0;
      cmd.edge_triggered <= 1'b0;
      cmd.one_shot <= 1'b0;
      cmd.user_data <= '0;
      cmd.ready_bits <= '0;
      cmd.max_events <= '0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) void'(pending_cmds.pop_front());
      if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= 12)) begin
        cmd.valid <= 1'b1;
        cmd.mode <= pending_cmds[0].mode;
        cmd.slot <= pending_cmds[0].slot;
        cmd.interest <= pending_cmds[0].interest;
        cmd.edge_triggered <= pending_cmds[0].edge_triggered;
        cmd.one_shot <= pending_cmds[0].one_shot;
        cmd.user_data <= pending_cmds[0].user_data;
        cmd.ready_bits <= pending_cmds[0].ready_bits;
        cmd.max_events <= pending_cmds[0].max_events;
        predict_item(pending_cmds[0]);
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (hold_req && !hold_done) begin
      hold_off <= 300;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      evt.ready <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        if (expected_evts.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d", $time,
                   evt.status, evt.event_slot);
          errors++;
        end else begin
          evt_item_t e;
          e = expected_evts.pop_front();
          if (e.status !== evt.status || e.event_valid !== evt.event_valid ||
              e.event_bits !== evt.event_bits || e.event_data !== evt.event_data ||
              e.event_slot !== evt.event_slot || e.last_result !== evt.last_result) begin
            $display("%0t: mismatch expected st=%0d v=%0d b=%h d=%h s=%0d l=%0d",
                     $time, e.status, e.event_valid, e.event_bits, e.event_data,
                     e.event_slot, e.last_result);
            $display("%0t:          actual   st=%0d v=%0d b=%h d=%h s=%0d l=%0d",
                     $time, evt.status, evt.event_valid, evt.event_bits,
                     evt.event_data, evt.event_slot, evt.last_result);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        evt.ready <= 1'b0;
      end else begin
        evt.ready <= no_idle || $urandom_range(0, 99) >= 12;
      end
    end
  end

  initial begin
    for (int s = 0; s < 64; s++) begin
      tv_valid[s] = 1'b0; tv_level[s] = 4'd0; tv_interest[s] = 4'd0;
      tv_edge[s] = 1'b0; tv_oneshot[s] = 1'b0; tv_word[s] = 64'd0;
      tv_seen[s] = 4'd0; tv_pending[s] = 4'd0; tv_reported[s] = 4'd0;
      tv_disarmed[s] = 1'b0; tv_closed[s] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode and the corner cases
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_MODIFY, 5, 15, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_DELETE, 63, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_NOTIFY, 9, 0, 15, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_CLOSE, 9, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_LEVEL, 0, 0, 15, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_LEVEL, 63, 0, 12, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, 0, 15, 0, 1));
    pending_cmds[$].user_data = '1;
    pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, 0, 3, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, 63, 0, 0, 1));
    pending_cmds[$].user_data = '0;
    pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, 1, 1, 0, 1));
    pending_cmds[$].edge_triggered = 1'b1;
    pending_cmds.push_back(make_cmd(res_pkg::MODE_NOTIFY, 1, 0, 1, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_LEVEL, 1, 0, 1, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 127));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_CLOSE, 63, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_NOTIFY, 63, 0, 3, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 64));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, 63, 10, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_MODIFY, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_NONE, 7, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_DELETE, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 65));
    while (pending_cmds.size() != 0) @(posedge clk);

    // fill many slots, then stall the receiver while commands keep coming
    for (int s = 0; s < 64; s++) begin
      pending_cmds.push_back(make_cmd(res_pkg::MODE_LEVEL, s, 0,
                                      $urandom_range(0, 15), 1));
      pending_cmds.push_back(make_cmd(res_pkg::MODE_ADD, s, $urandom_range(0, 15),
                                      0, 1));
    end
    pending_cmds.push_back(make_cmd(res_pkg::MODE_COLLECT, 0, 0, 0, 64));
    for (int i = 0; i < 20; i++) pending_cmds.push_back(random_cmd());
    no_idle = 1;
    @(posedge clk);
    hold_req = 1;
    while (pending_cmds.size() != 0) @(posedge clk);
    no_idle = 0;

    for (int i = 0; i < 200; i++) pending_cmds.push_back(random_cmd());
    while (pending_cmds.size() != 0) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (expected_evts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_evts.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
